@@ design/sc2d_pkg.sv @@
// Shared types, codes and constants for the stencil convolution block.
`timescale 1ns / 1ps
package sc2d_pkg;

  localparam int SMP_W      = 16;
  localparam int COEF_W     = 16;
  localparam int RES_W      = 20;
  localparam int COORD_W    = 6;
  localparam int OP_W       = 2;
  localparam int CIDX_W     = 6;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 7;
  localparam int LANES      = 4;

  localparam int RES_MAX     = 524287;
  localparam int RES_MIN     = -524288;
  localparam int ROUND_HALF  = 2048;
  localparam int ROUND_SHIFT = 12;

  localparam logic [OP_W-1:0] OP_COEF  = 2'd0;
  localparam logic [OP_W-1:0] OP_PIXEL = 2'd1;
  localparam logic [OP_W-1:0] OP_EMIT  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CHANNELS     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_RADIUS       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_WRAP         = 3'd4;

  typedef struct packed {
    logic coef_we;
    logic pix_we;
    logic emit_start;
    logic tap_init;
    logic tap_step;
    logic finish;
  } ctrl_cmd_t;

  typedef struct packed {
    logic div_done;
    logic tap_last;
    logic pipe_busy;
    logic out_free;
  } dp_status_t;

endpackage

@@ design/sc2d_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module sc2d_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 49
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ design/sc2d_div.sv @@
// Restoring divider, one quotient bit per cycle; splits a raster position into row and column.
`timescale 1ns / 1ps
module sc2d_div #(
  parameter int NW = 12,
  parameter int DW = 7
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [NW-1:0] dividend,
  input  logic [DW-1:0] divisor,
  output logic          busy,
  output logic [NW-1:0] quot,
  output logic [DW-1:0] rem
);

  localparam int CW = $clog2(NW + 1);

  logic [NW-1:0] n_r;
  logic [DW-1:0] d_r;
  logic [DW-1:0] rem_r;
  logic [CW-1:0] cnt_r;
  logic [DW:0]   rem_sh;
  logic          ge;

  assign rem_sh = {rem_r, n_r[NW-1]};
  assign ge     = rem_sh >= {1'b0, d_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (start) begin
      cnt_r <= CW'(NW);
    end else if (cnt_r != '0) begin
      cnt_r <= cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      n_r   <= dividend;
      d_r   <= divisor;
      rem_r <= '0;
    end else if (cnt_r != '0) begin
      rem_r <= ge ? DW'(rem_sh - {1'b0, d_r}) : rem_sh[DW-1:0];
      n_r   <= {n_r[NW-2:0], ge};
    end
  end

  assign busy = cnt_r != '0;
  assign quot = n_r;
  assign rem  = rem_r;

endmodule

@@ design/sc2d_datapath.sv @@
// Datapath: config registers, stores, position counters, tap walk, MAC lanes, output register.
`timescale 1ns / 1ps
module sc2d_datapath #(
  parameter int MAX_WIDTH    = 64,
  parameter int MAX_HEIGHT   = 64,
  parameter int MAX_RADIUS   = 3,
  parameter int MAX_CHANNELS = 4
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  sc2d_pkg::ctrl_cmd_t                 cmd,
  output sc2d_pkg::dp_status_t                status,
  input  logic                                cfg_we,
  input  logic [sc2d_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [sc2d_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic [sc2d_pkg::CIDX_W-1:0]         in_coef_index,
  input  logic [sc2d_pkg::COEF_W-1:0]         in_coef_value,
  input  logic [sc2d_pkg::SMP_W-1:0]          in_sample [sc2d_pkg::LANES],
  input  logic                                out_stall,
  output logic                                out_valid,
  output logic [sc2d_pkg::COORD_W-1:0]        out_col,
  output logic [sc2d_pkg::COORD_W-1:0]        out_row,
  output logic signed [sc2d_pkg::RES_W-1:0]   out_result [sc2d_pkg::LANES],
  output logic                                out_frame_done
);

  localparam int WW         = $clog2(MAX_WIDTH + 1);
  localparam int HW         = $clog2(MAX_HEIGHT + 1);
  localparam int CHW        = $clog2(MAX_CHANNELS + 1);
  localparam int RW         = $clog2(MAX_RADIUS + 1);
  localparam int FDEPTH     = MAX_WIDTH * MAX_HEIGHT;
  localparam int PW         = $clog2(FDEPTH);
  localparam int TW         = $clog2(FDEPTH + 1);
  localparam int CDEPTH     = (2 * MAX_RADIUS + 1) * (2 * MAX_RADIUS + 1);
  localparam int CAW        = $clog2(CDEPTH);
  localparam int CIW        = (CAW > sc2d_pkg::CIDX_W) ? CAW : sc2d_pkg::CIDX_W;
  localparam int PROD_W     = sc2d_pkg::COEF_W + sc2d_pkg::SMP_W + 1;
  localparam int ACC_W      = PROD_W + $clog2(CDEPTH) + 1;
  localparam int FW         = sc2d_pkg::SMP_W * MAX_CHANNELS;
  localparam int SX         = WW + 2;
  localparam int SY         = HW + 2;

  localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'(sc2d_pkg::RES_MAX);
  localparam logic signed [ACC_W-1:0] SAT_LO = ACC_W'(sc2d_pkg::RES_MIN);

  // configuration
  logic [6:0] fw_r, fh_r;
  logic [2:0] cc_r;
  logic [1:0] sr_r;
  logic       wrap_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fw_r   <= 7'd64;
      fh_r   <= 7'd64;
      cc_r   <= 3'd4;
      sr_r   <= 2'd1;
      wrap_r <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        sc2d_pkg::CFG_FRAME_WIDTH:  fw_r   <= cfg_data;
        sc2d_pkg::CFG_FRAME_HEIGHT: fh_r   <= cfg_data;
        sc2d_pkg::CFG_CHANNELS:     cc_r   <= cfg_data[2:0];
        sc2d_pkg::CFG_RADIUS:       sr_r   <= cfg_data[1:0];
        sc2d_pkg::CFG_WRAP:         wrap_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  logic [WW-1:0]  w_c;
  logic [HW-1:0]  h_c;
  logic [CHW-1:0] ch_c;
  logic [RW-1:0]  r_c;
  logic [TW-1:0]  total;

  assign w_c  = (fw_r < 7'd4) ? WW'(4) :
                (32'(fw_r) > MAX_WIDTH) ? WW'(MAX_WIDTH) : WW'(fw_r);
  assign h_c  = (fh_r < 7'd4) ? HW'(4) :
                (32'(fh_r) > MAX_HEIGHT) ? HW'(MAX_HEIGHT) : HW'(fh_r);
  assign ch_c = (cc_r == 3'd0) ? CHW'(1) :
                (32'(cc_r) > MAX_CHANNELS) ? CHW'(MAX_CHANNELS) : CHW'(cc_r);
  assign r_c  = (sr_r == 2'd0) ? RW'(1) :
                (32'(sr_r) > MAX_RADIUS) ? RW'(MAX_RADIUS) : RW'(sr_r);
  assign total = TW'(w_c) * TW'(h_c);

  // positions
  logic [PW-1:0] load_pos_r, emit_pos_r, em_pos_r;
  logic [PW-1:0] lp_eff, ep_eff;
  logic          em_last;

  assign lp_eff  = (TW'(load_pos_r) >= total) ? '0 : load_pos_r;
  assign ep_eff  = (TW'(emit_pos_r) >= total) ? '0 : emit_pos_r;
  assign em_last = (TW'(em_pos_r) + 1'b1) >= total;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      load_pos_r <= '0;
      emit_pos_r <= '0;
    end else begin
      if (cmd.pix_we) begin
        load_pos_r <= ((TW'(lp_eff) + 1'b1) >= total) ? '0 : PW'(lp_eff + 1'b1);
      end
      if (cmd.finish) begin
        emit_pos_r <= em_last ? '0 : PW'(em_pos_r + 1'b1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_start) begin
      em_pos_r <= ep_eff;
    end
  end

  // row / column of the output pixel
  logic          div_busy;
  logic [PW-1:0] div_quot;
  logic [WW-1:0] div_rem;

  sc2d_div #(.NW(PW), .DW(WW)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.emit_start),
    .dividend (ep_eff),
    .divisor  (w_c),
    .busy     (div_busy),
    .quot     (div_quot),
    .rem      (div_rem)
  );

  // tap walk
  logic [WW-1:0]        x_r;
  logic [HW-1:0]        y_r;
  logic signed [RW:0]   dx_r, dy_r, r_s;
  logic [CAW-1:0]       ci_r;

  assign r_s = $signed({1'b0, r_c});

  always_ff @(posedge clk) begin
    if (cmd.tap_init) begin
      x_r  <= div_rem;
      y_r  <= div_quot[HW-1:0];
      dx_r <= -r_s;
      dy_r <= -r_s;
      ci_r <= '0;
    end else if (cmd.tap_step) begin
      ci_r <= ci_r + 1'b1;
      if (dx_r == r_s) begin
        dx_r <= -r_s;
        dy_r <= dy_r + 1'b1;
      end else begin
        dx_r <= dx_r + 1'b1;
      end
    end
  end

  logic signed [SX-1:0] xs, xw, w_s;
  logic signed [SY-1:0] ys, yw, h_s;
  logic                 x_lo, x_hi, y_lo, y_hi, tap_ok;

  assign w_s  = $signed({2'b00, w_c});
  assign h_s  = $signed({2'b00, h_c});
  assign xs   = $signed({2'b00, x_r}) + SX'(dx_r);
  assign ys   = $signed({2'b00, y_r}) + SY'(dy_r);
  assign x_lo = xs < 0;
  assign x_hi = xs >= w_s;
  assign y_lo = ys < 0;
  assign y_hi = ys >= h_s;
  assign xw   = x_lo ? xs + w_s : (x_hi ? xs - w_s : xs);
  assign yw   = y_lo ? ys + h_s : (y_hi ? ys - h_s : ys);
  assign tap_ok = wrap_r || !(x_lo || x_hi || y_lo || y_hi);

  // stage 1: tap coordinates
  logic           t1_valid_r, t2_valid_r, t3_valid_r;
  logic [WW-1:0]  x1_r;
  logic [HW-1:0]  y1_r;
  logic [CAW-1:0] ci1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      t1_valid_r <= 1'b0;
      t2_valid_r <= 1'b0;
      t3_valid_r <= 1'b0;
    end else begin
      t1_valid_r <= cmd.tap_step && tap_ok;
      t2_valid_r <= t1_valid_r;
      t3_valid_r <= t2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    x1_r  <= xw[WW-1:0];
    y1_r  <= yw[HW-1:0];
    ci1_r <= ci_r;
  end

  // stores
  logic [CIW-1:0]             cidx;
  logic                       coef_we;
  logic [sc2d_pkg::COEF_W-1:0] coef_rdata;
  logic [FW-1:0]              pix_wdata, pix_rdata;
  logic [PW-1:0]              pix_raddr;

  assign cidx      = CIW'(in_coef_index);
  assign coef_we   = cmd.coef_we && (32'(in_coef_index) < CDEPTH);
  assign pix_raddr = PW'(PW'(y1_r) * PW'(w_c)) + PW'(x1_r);

  always_comb begin
    for (int c = 0; c < MAX_CHANNELS; c++) begin
      pix_wdata[c*sc2d_pkg::SMP_W +: sc2d_pkg::SMP_W] = in_sample[c];
    end
  end

  sc2d_ram #(.WIDTH(sc2d_pkg::COEF_W), .DEPTH(CDEPTH)) u_coef_ram (
    .clk   (clk),
    .we    (coef_we),
    .waddr (cidx[CAW-1:0]),
    .wdata (in_coef_value),
    .re    (t1_valid_r),
    .raddr (ci1_r),
    .rdata (coef_rdata)
  );

  sc2d_ram #(.WIDTH(FW), .DEPTH(FDEPTH)) u_frame_ram (
    .clk   (clk),
    .we    (cmd.pix_we),
    .waddr (lp_eff),
    .wdata (pix_wdata),
    .re    (t1_valid_r),
    .raddr (pix_raddr),
    .rdata (pix_rdata)
  );

  // MAC lanes
  logic signed [PROD_W-1:0] prod_r [MAX_CHANNELS];
  logic signed [ACC_W-1:0]  acc_r  [MAX_CHANNELS];

  always_ff @(posedge clk) begin
    for (int c = 0; c < MAX_CHANNELS; c++) begin
      prod_r[c] <= $signed(coef_rdata) *
                   $signed({1'b0, pix_rdata[c*sc2d_pkg::SMP_W +: sc2d_pkg::SMP_W]});
      if (cmd.tap_init) begin
        acc_r[c] <= '0;
      end else if (t3_valid_r) begin
        acc_r[c] <= acc_r[c] + ACC_W'(prod_r[c]);
      end
    end
  end

  // round half up, saturate
  logic signed [ACC_W-1:0]          rnd  [MAX_CHANNELS];
  logic signed [sc2d_pkg::RES_W-1:0] sat [MAX_CHANNELS];

  always_comb begin
    for (int c = 0; c < MAX_CHANNELS; c++) begin
      rnd[c] = (acc_r[c] + ACC_W'(sc2d_pkg::ROUND_HALF)) >>> sc2d_pkg::ROUND_SHIFT;
      if (rnd[c] > SAT_HI) begin
        sat[c] = sc2d_pkg::RES_W'(sc2d_pkg::RES_MAX);
      end else if (rnd[c] < SAT_LO) begin
        sat[c] = sc2d_pkg::RES_W'(sc2d_pkg::RES_MIN);
      end else begin
        sat[c] = rnd[c][sc2d_pkg::RES_W-1:0];
      end
      if (32'(ch_c) <= c) begin
        sat[c] = '0;
      end
    end
  end

  // output register
  logic                               out_valid_r;
  logic                               out_free;
  logic [sc2d_pkg::COORD_W-1:0]       col_r, row_r;
  logic signed [sc2d_pkg::RES_W-1:0]  res_r [MAX_CHANNELS];
  logic                               done_r;

  assign out_free = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.finish) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      col_r  <= sc2d_pkg::COORD_W'(x_r);
      row_r  <= sc2d_pkg::COORD_W'(y_r);
      done_r <= em_last;
      for (int c = 0; c < MAX_CHANNELS; c++) begin
        res_r[c] <= sat[c];
      end
    end
  end

  for (genvar g = 0; g < sc2d_pkg::LANES; g++) begin : g_res
    if (g < MAX_CHANNELS) begin : g_on
      assign out_result[g] = res_r[g];
    end else begin : g_off
      assign out_result[g] = '0;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_col        = col_r;
  assign out_row        = row_r;
  assign out_frame_done = done_r;

  assign status.div_done  = !div_busy;
  assign status.tap_last  = (dx_r == r_s) && (dy_r == r_s);
  assign status.pipe_busy = t1_valid_r || t2_valid_r || t3_valid_r;
  assign status.out_free  = out_free;

endmodule

@@ design/sc2d_ctrl.sv @@
// Controller: request decode and sequencing of one output pixel.
`timescale 1ns / 1ps
module sc2d_ctrl (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  input  logic [sc2d_pkg::OP_W-1:0]    in_op,
  input  sc2d_pkg::dp_status_t         status,
  output sc2d_pkg::ctrl_cmd_t          cmd,
  output logic                         in_stall
);

  typedef enum logic [2:0] {S_IDLE, S_DIV, S_TAP, S_DRAIN, S_FIN} state_t;

  state_t state_r, state_nxt;
  logic   in_stall_r;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          case (in_op)
            sc2d_pkg::OP_COEF:  cmd.coef_we = 1'b1;
            sc2d_pkg::OP_PIXEL: cmd.pix_we  = 1'b1;
            sc2d_pkg::OP_EMIT: begin
              cmd.emit_start = 1'b1;
              state_nxt      = S_DIV;
            end
            default: ;
          endcase
        end
      end
      S_DIV: begin
        if (status.div_done) begin
          cmd.tap_init = 1'b1;
          state_nxt    = S_TAP;
        end
      end
      S_TAP: begin
        cmd.tap_step = 1'b1;
        if (status.tap_last) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (!status.pipe_busy) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (status.out_free) begin
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      in_stall_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      in_stall_r <= state_nxt != S_IDLE;
    end
  end

  assign in_stall = in_stall_r;

endmodule

@@ design/stencil_convolution_2d_top.sv @@
// Top level of the square-stencil 2D convolution block.
//
//  channel | direction | handshake          | payload
//  in_     | in        | in_valid/in_stall  | op, coef_index, coef_value, sample0..3
//  out_    | out       | out_valid/out_stall| col, row, result0..3, frame_done
//  cfg_    | in        | cfg_valid/cfg_ready| index, data
//
// Coefficient and pixel requests do not stall the input.
// An emit request runs the position divider, then one stencil tap per cycle through the
// frame store read port, then drains the MAC pipeline before writing the result.
// rst_n is synchronous; it resets positions, configuration registers and handshake state, not the stores.
// The input stays stalled for the whole emit; a result still stalled at the output holds
// the emit in its final cycle until the output register frees.
`timescale 1ns / 1ps
module stencil_convolution_2d_top #(
  parameter int MAX_WIDTH    = 64,
  parameter int MAX_HEIGHT   = 64,
  parameter int MAX_RADIUS   = 3,
  parameter int MAX_CHANNELS = 4
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [sc2d_pkg::OP_W-1:0]          in_op,
  input  logic [sc2d_pkg::CIDX_W-1:0]        in_coef_index,
  input  logic signed [sc2d_pkg::COEF_W-1:0] in_coef_value,
  input  logic [sc2d_pkg::SMP_W-1:0]         in_sample0,
  input  logic [sc2d_pkg::SMP_W-1:0]         in_sample1,
  input  logic [sc2d_pkg::SMP_W-1:0]         in_sample2,
  input  logic [sc2d_pkg::SMP_W-1:0]         in_sample3,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [sc2d_pkg::COORD_W-1:0]       out_col,
  output logic [sc2d_pkg::COORD_W-1:0]       out_row,
  output logic signed [sc2d_pkg::RES_W-1:0]  out_result0,
  output logic signed [sc2d_pkg::RES_W-1:0]  out_result1,
  output logic signed [sc2d_pkg::RES_W-1:0]  out_result2,
  output logic signed [sc2d_pkg::RES_W-1:0]  out_result3,
  output logic                               out_frame_done,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [sc2d_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [sc2d_pkg::CFG_DATA_W-1:0]    cfg_data
);

  sc2d_pkg::ctrl_cmd_t  cmd;
  sc2d_pkg::dp_status_t status;

  logic [sc2d_pkg::SMP_W-1:0]        smp [sc2d_pkg::LANES];
  logic signed [sc2d_pkg::RES_W-1:0] res [sc2d_pkg::LANES];

  assign smp[0] = in_sample0;
  assign smp[1] = in_sample1;
  assign smp[2] = in_sample2;
  assign smp[3] = in_sample3;

  assign out_result0 = res[0];
  assign out_result1 = res[1];
  assign out_result2 = res[2];
  assign out_result3 = res[3];

  assign cfg_ready = 1'b1;

  sc2d_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_op    (in_op),
    .status   (status),
    .cmd      (cmd),
    .in_stall (in_stall)
  );

  sc2d_datapath #(
    .MAX_WIDTH    (MAX_WIDTH),
    .MAX_HEIGHT   (MAX_HEIGHT),
    .MAX_RADIUS   (MAX_RADIUS),
    .MAX_CHANNELS (MAX_CHANNELS)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .status         (status),
    .cfg_we         (cfg_valid && cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_coef_index  (in_coef_index),
    .in_coef_value  (in_coef_value),
    .in_sample      (smp),
    .out_stall      (out_stall),
    .out_valid      (out_valid),
    .out_col        (out_col),
    .out_row        (out_row),
    .out_result     (res),
    .out_frame_done (out_frame_done)
  );

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |-> status.out_free)
    else $error("result register overwritten");

  a_acc_settled: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |-> !status.pipe_busy)
    else $error("result taken before accumulation finished");

  a_emit_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && in_op == sc2d_pkg::OP_EMIT) |=> in_stall)
    else $error("request accepted during emit");

endmodule

@@ test/stencil_convolution_2d_top_test.sv @@
// Self-checking testbench for the stencil convolution top level: directed and random requests, scoreboard.
`timescale 1ns / 1ps
module stencil_convolution_2d_top_test;

  localparam logic [sc2d_pkg::OP_W-1:0] OP_NONE = 2'd3;
  localparam int COEF_CELLS = 49;

  typedef struct {
    logic [sc2d_pkg::OP_W-1:0]   op;
    logic [sc2d_pkg::CIDX_W-1:0] cidx;
    logic [sc2d_pkg::COEF_W-1:0] cval;
    logic [sc2d_pkg::SMP_W-1:0]  smp [sc2d_pkg::LANES];
  } conv_req_t;

  typedef struct {
    logic [sc2d_pkg::COORD_W-1:0] col;
    logic [sc2d_pkg::COORD_W-1:0] row;
    logic [sc2d_pkg::RES_W-1:0]   res [sc2d_pkg::LANES];
    logic                         done;
  } conv_pix_t;

  class conv_scoreboard;
    logic [sc2d_pkg::COEF_W-1:0] coef_mem [COEF_CELLS];
    logic [sc2d_pkg::SMP_W-1:0]  frame_mem [4096][sc2d_pkg::LANES];
    int unsigned load_pos, emit_pos;
    int unsigned reg_w, reg_h, reg_ch, reg_r, reg_wrap;
    conv_pix_t expected_pixels [$];
    int errors;

    function void reset_state();
      load_pos = 0; emit_pos = 0;
      reg_w = 64; reg_h = 64; reg_ch = 4; reg_r = 1; reg_wrap = 0;
      errors = 0;
    endfunction

    function void set_reg(logic [sc2d_pkg::CFG_IDX_W-1:0] idx,
                          logic [sc2d_pkg::CFG_DATA_W-1:0] val);
      case (idx)
        sc2d_pkg::CFG_FRAME_WIDTH:  reg_w = 32'(val);
        sc2d_pkg::CFG_FRAME_HEIGHT: reg_h = 32'(val);
        sc2d_pkg::CFG_CHANNELS:     reg_ch = 32'(val[2:0]);
        sc2d_pkg::CFG_RADIUS:       reg_r = 32'(val[1:0]);
        sc2d_pkg::CFG_WRAP:         reg_wrap = 32'(val[0]);
        default: ;
      endcase
    endfunction

    function int lim(int unsigned v, int lo, int hi);
      if (v < lo) return lo;
      if (v > hi) return hi;
      return int'(v);
    endfunction

    function int unsigned frame_total();
      return 32'(lim(reg_w, 4, 64) * lim(reg_h, 4, 64));
    endfunction

    function void note_request(conv_req_t rq);
      int w, h, ch, r, side, x, y, yy, xx, ci;
      int unsigned total;
      longint acc [sc2d_pkg::LANES];
      longint coef, q;
      conv_pix_t px;
      w = lim(reg_w, 4, 64); h = lim(reg_h, 4, 64);
      ch = lim(reg_ch, 1, sc2d_pkg::LANES); r = lim(reg_r, 1, 3);
      side = 2 * r + 1;
      total = 32'(w * h);
      case (rq.op)
        sc2d_pkg::OP_COEF: if (rq.cidx < COEF_CELLS) coef_mem[rq.cidx] = rq.cval;
        sc2d_pkg::OP_PIXEL: begin
          if (load_pos >= total) load_pos = 0;
          for (int c = 0; c < sc2d_pkg::LANES; c++) frame_mem[load_pos][c] = rq.smp[c];
          load_pos = (load_pos + 1 >= total) ? 0 : load_pos + 1;
        end
        sc2d_pkg::OP_EMIT: begin
          if (emit_pos >= total) emit_pos = 0;
          x = int'(emit_pos % w); y = int'(emit_pos / w);
          for (int c = 0; c < sc2d_pkg::LANES; c++) acc[c] = 0;
          for (int dy = -r; dy <= r; dy++) begin
            yy = y + dy;
            if (yy < 0 || yy >= h) begin
              if (reg_wrap == 0) continue;
              yy = (yy + h) % h;
            end
            for (int dx = -r; dx <= r; dx++) begin
              xx = x + dx;
              if (xx < 0 || xx >= w) begin
                if (reg_wrap == 0) continue;
                xx = (xx + w) % w;
              end
              ci = (dy + r) * side + (dx + r);
              coef = longint'($signed(coef_mem[ci]));
              for (int c = 0; c < ch; c++)
                acc[c] += coef * longint'(frame_mem[yy * w + xx][c]);
            end
          end
          px.col = sc2d_pkg::COORD_W'(x); px.row = sc2d_pkg::COORD_W'(y);
          for (int c = 0; c < sc2d_pkg::LANES; c++) begin
            q = (acc[c] + sc2d_pkg::ROUND_HALF) >>> sc2d_pkg::ROUND_SHIFT;
            if (q > sc2d_pkg::RES_MAX) q = sc2d_pkg::RES_MAX;
            if (q < sc2d_pkg::RES_MIN) q = sc2d_pkg::RES_MIN;
            px.res[c] = (c < ch) ? q[sc2d_pkg::RES_W-1:0] : '0;
          end
          px.done = (emit_pos + 1 >= total);
          emit_pos = px.done ? 0 : emit_pos + 1;
          expected_pixels.push_back(px);
        end
        default: ;
      endcase
    endfunction

    function void check_result(conv_pix_t got);
      conv_pix_t exp_px;
      if (expected_pixels.size() == 0) begin
        $display("%0t: unexpected output pixel col %0d row %0d", $realtime, got.col, got.row);
        errors++;
        return;
      end
      exp_px = expected_pixels.pop_front();
      if (got.col !== exp_px.col) begin
        $display("%0t: col exp %0d got %0d", $realtime, exp_px.col, got.col); errors++;
      end
      if (got.row !== exp_px.row) begin
        $display("%0t: row exp %0d got %0d", $realtime, exp_px.row, got.row); errors++;
      end
      for (int c = 0; c < sc2d_pkg::LANES; c++)
        if (got.res[c] !== exp_px.res[c]) begin
          $display("%0t: result%0d exp %0d got %0d", $realtime, c,
                   $signed(exp_px.res[c]), $signed(got.res[c]));
          errors++;
        end
      if (got.done !== exp_px.done) begin
        $display("%0t: frame_done exp %0b got %0b", $realtime, exp_px.done, got.done);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0, in_stall;
  logic [sc2d_pkg::OP_W-1:0] in_op = '0;
  logic [sc2d_pkg::CIDX_W-1:0] in_coef_index = '0;
  logic signed [sc2d_pkg::COEF_W-1:0] in_coef_value = '0;
  logic [sc2d_pkg::SMP_W-1:0] in_sample0 = '0, in_sample1 = '0;
  logic [sc2d_pkg::SMP_W-1:0] in_sample2 = '0, in_sample3 = '0;
  logic out_valid, out_stall = 1'b0;
  logic [sc2d_pkg::COORD_W-1:0] out_col, out_row;
  logic signed [sc2d_pkg::RES_W-1:0] out_result0, out_result1, out_result2, out_result3;
  logic out_frame_done;
  logic cfg_valid = 1'b0, cfg_ready;
  logic [sc2d_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [sc2d_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  conv_scoreboard sb = new();
  int idle_in = 29, idle_out = 76, hold_cycles = 0;

  stencil_convolution_2d_top u_dut (.*);

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  initial begin
    #20ms;
    $display("stencil_convolution_2d_top_test: done, errors");
    $finish;
  end

  initial begin
    conv_pix_t got;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) begin
        got.col = out_col; got.row = out_row; got.done = out_frame_done;
        got.res[0] = out_result0; got.res[1] = out_result1;
        got.res[2] = out_result2; got.res[3] = out_result3;
        sb.check_result(got);
      end
      if (hold_cycles > 0) begin
        hold_cycles--;
        out_stall <= 1'b1;
      end else
        out_stall <= ($urandom_range(99) < idle_out);
    end
  end

  task automatic send_request(conv_req_t rq);
    while ($urandom_range(99) < idle_in) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_op <= rq.op;
    in_coef_index <= rq.cidx;
    in_coef_value <= rq.cval;
    in_sample0 <= rq.smp[0]; in_sample1 <= rq.smp[1];
    in_sample2 <= rq.smp[2]; in_sample3 <= rq.smp[3];
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_request(rq);
  endtask

  function automatic conv_req_t make_req(logic [sc2d_pkg::OP_W-1:0] op, int cidx, int cval,
                                         int smp);
    conv_req_t rq;
    rq.op = op;
    rq.cidx = sc2d_pkg::CIDX_W'(cidx);
    rq.cval = sc2d_pkg::COEF_W'(cval);
    for (int c = 0; c < sc2d_pkg::LANES; c++)
      rq.smp[c] = (smp < 0) ? sc2d_pkg::SMP_W'($urandom) : sc2d_pkg::SMP_W'(smp);
    return rq;
  endfunction

  function automatic conv_req_t rand_req();
    int pick = $urandom_range(99);
    conv_req_t rq = make_req(sc2d_pkg::OP_EMIT, $urandom_range(63), $urandom, -1);
    if (pick < 15) rq.op = sc2d_pkg::OP_COEF;
    else if (pick < 33) rq.op = sc2d_pkg::OP_PIXEL;
    else if (pick < 38) rq.op = OP_NONE;
    return rq;
  endfunction

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.expected_pixels.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  task automatic write_reg(logic [sc2d_pkg::CFG_IDX_W-1:0] idx,
                           logic [sc2d_pkg::CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.set_reg(idx, val);
  endtask

  task automatic configure(int w, int h, int ch, int r, int wrap);
    write_reg(sc2d_pkg::CFG_FRAME_WIDTH, sc2d_pkg::CFG_DATA_W'(w));
    write_reg(sc2d_pkg::CFG_FRAME_HEIGHT, sc2d_pkg::CFG_DATA_W'(h));
    write_reg(sc2d_pkg::CFG_CHANNELS, sc2d_pkg::CFG_DATA_W'(ch));
    write_reg(sc2d_pkg::CFG_RADIUS, sc2d_pkg::CFG_DATA_W'(r));
    write_reg(sc2d_pkg::CFG_WRAP, sc2d_pkg::CFG_DATA_W'(wrap));
    cfg_valid <= 1'b0;
  endtask

  // every frame entry written before any emit of this geometry
  task automatic fill_frame(int smp);
    int unsigned n = sb.frame_total();
    for (int i = 0; i < n; i++) send_request(make_req(sc2d_pkg::OP_PIXEL, 0, 0, smp));
  endtask

  initial begin
    int pw [6] = '{4, 64, 4, 127, 5, 8};
    int ph [6] = '{4, 4, 64, 2, 7, 6};
    int pc [6] = '{4, 4, 2, 0, 3, 7};
    int pr [6] = '{1, 3, 2, 0, 3, 1};
    int pwr [6] = '{0, 1, 0, 1, 1, 0};
    sb.reset_state();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    configure(4, 4, 4, 3, 0);
    for (int i = 0; i < COEF_CELLS; i++)
      send_request(make_req(sc2d_pkg::OP_COEF, i, 32767, 0));
    fill_frame(65535);
    send_request(make_req(sc2d_pkg::OP_EMIT, 0, 0, 0));
    send_request(make_req(sc2d_pkg::OP_EMIT, 0, 0, 0));
    send_request(make_req(sc2d_pkg::OP_COEF, 63, 1, 0));
    send_request(make_req(OP_NONE, 0, 0, 0));
    for (int i = 0; i < COEF_CELLS; i++)
      send_request(make_req(sc2d_pkg::OP_COEF, i, -32768, 0));
    send_request(make_req(sc2d_pkg::OP_EMIT, 0, 0, 0));
    fill_frame(0);
    send_request(make_req(sc2d_pkg::OP_EMIT, 0, 0, 0));
    for (int i = 0; i < COEF_CELLS; i++)
      send_request(make_req(sc2d_pkg::OP_COEF, i, int'($urandom_range(2047)) - 1024, 0));

    for (int p = 0; p < 6; p++) begin
      wait_drained();
      if (p < 2) begin idle_in = 29; idle_out = 76; end
      else if (p < 4) begin idle_in = 76; idle_out = 29; end
      else begin idle_in = 0; idle_out = 0; end
      configure(pw[p], ph[p], pc[p], pr[p], pwr[p]);
      fill_frame(-1);
      if (p == 1) hold_cycles = 600;
      for (int i = 0; i < 50; i++) begin
        send_request(rand_req());
        if (p == 4 && i == 25) wait_drained();
      end
    end

    wait_drained();
    if (sb.errors == 0)
      $display("stencil_convolution_2d_top_test: done, clean");
    else
      $display("stencil_convolution_2d_top_test: done, errors");
    $finish;
  end

endmodule

@@ stencil_convolution_2d_top.f @@
design/sc2d_pkg.sv
design/sc2d_ram.sv
design/sc2d_div.sv
design/sc2d_datapath.sv
design/sc2d_ctrl.sv
design/stencil_convolution_2d_top.sv
test/stencil_convolution_2d_top_test.sv
